FILE: rtl/usg_pkg.sv
`timescale 1ns / 1ps

package usg_pkg;

    localparam int FIELD_W   = 15;
    localparam int FIELD_MAX = (1 << FIELD_W) - 1;

    localparam logic [FIELD_W-1:0] HORIZON_RESET = 15'd20000;

    localparam int          PADDR_W     = 3;
    localparam int          PDATA_W     = 32;
    localparam logic [0:0]  REG_HORIZON = 1'b0;

    localparam logic [1:0] REP_ZERO = 2'd0;
    localparam logic [1:0] REP_ONE  = 2'd1;
    localparam logic [1:0] REP_TWO  = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] first_seed;
        logic [FIELD_W-1:0] second_seed;
    } seed_word_t;

    typedef struct packed {
        logic               has_term;
        logic [FIELD_W-1:0] even_term;
        logic [FIELD_W-1:0] term_count;
        logic [FIELD_W-1:0] even_count;
        logic [FIELD_W-1:0] max_even;
        logic               bad_pair;
        logic               last;
    } result_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BAD,
        S_CLEAR,
        S_SEED_A,
        S_SEED_B,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_BUMP_RD,
        S_BUMP_SUM,
        S_BUMP_WR,
        S_ADD,
        S_EMIT_START,
        S_EMIT_NONE,
        S_EMIT_RD,
        S_EMIT_CHK
    } state_t;

    typedef struct packed {
        logic seed_load;
        logic clr_init;
        logic clr_write;
        logic seed_a_add;
        logic seed_b_add;
        logic rep_rd_x;
        logic x_inc;
        logic bump_init;
        logic term_rd_i;
        logic rep_rd_s;
        logic rep_bump;
        logic x_add;
        logic emit_init;
        logic term_rd_j;
        logic j_inc;
        logic out_term;
        logic out_none;
        logic out_bad;
    } cmd_t;

    typedef struct packed {
        logic bad_seeds;
        logic clr_done;
        logic b_in_range;
        logic rep_is_one;
        logic x_at_n;
        logic i_at_k;
        logic sum_over;
        logic no_even;
        logic term_even;
        logic last_even;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/usg_if.sv
`timescale 1ns / 1ps

interface usg_seed_if;
    import usg_pkg::*;

    logic       valid;
    logic       ready;
    seed_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface usg_result_if;
    import usg_pkg::*;

    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/usg_ram.sv
`timescale 1ns / 1ps

module usg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/usg_ctrl.sv
`timescale 1ns / 1ps

module usg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_valid,
    output logic              seed_ready,
    input  usg_pkg::status_t  status,
    output usg_pkg::cmd_t     cmd
);

    import usg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (seed_valid)
                begin
                    state_next = status.bad_seeds ? S_BAD : S_CLEAR;
                end
            end
            S_BAD:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = S_SEED_A;
                end
            end
            S_SEED_A:
            begin
                state_next = S_SEED_B;
            end
            S_SEED_B:
            begin
                state_next = status.b_in_range ? S_SCAN_RD : S_EMIT_START;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (status.rep_is_one)
                begin
                    state_next = S_BUMP_RD;
                end
                else if (status.x_at_n)
                begin
                    state_next = S_EMIT_START;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_BUMP_RD:
            begin
                state_next = status.i_at_k ? S_ADD : S_BUMP_SUM;
            end
            S_BUMP_SUM:
            begin
                state_next = status.sum_over ? S_ADD : S_BUMP_WR;
            end
            S_BUMP_WR:
            begin
                state_next = S_BUMP_RD;
            end
            S_ADD:
            begin
                state_next = status.x_at_n ? S_EMIT_START : S_SCAN_RD;
            end
            S_EMIT_START:
            begin
                state_next = status.no_even ? S_EMIT_NONE : S_EMIT_RD;
            end
            S_EMIT_NONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_CHK;
            end
            S_EMIT_CHK:
            begin
                if (!status.term_even)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (status.out_free)
                begin
                    state_next = status.last_even ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        seed_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                seed_ready     = 1'b1;
                cmd.seed_load  = seed_valid;
                cmd.clr_init   = seed_valid && !status.bad_seeds;
            end
            S_BAD:
            begin
                cmd.out_bad = status.out_free;
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
            end
            S_SEED_A:
            begin
                cmd.seed_a_add = 1'b1;
            end
            S_SEED_B:
            begin
                cmd.seed_b_add = 1'b1;
            end
            S_SCAN_RD:
            begin
                cmd.rep_rd_x = 1'b1;
            end
            S_SCAN_CHK:
            begin
                cmd.bump_init = status.rep_is_one;
                cmd.x_inc     = !status.rep_is_one && !status.x_at_n;
            end
            S_BUMP_RD:
            begin
                cmd.term_rd_i = !status.i_at_k;
            end
            S_BUMP_SUM:
            begin
                cmd.rep_rd_s = !status.sum_over;
            end
            S_BUMP_WR:
            begin
                cmd.rep_bump = 1'b1;
            end
            S_ADD:
            begin
                cmd.x_add = 1'b1;
                cmd.x_inc = !status.x_at_n;
            end
            S_EMIT_START:
            begin
                cmd.emit_init = 1'b1;
            end
            S_EMIT_NONE:
            begin
                cmd.out_none = status.out_free;
            end
            S_EMIT_RD:
            begin
                cmd.term_rd_j = 1'b1;
            end
            S_EMIT_CHK:
            begin
                cmd.j_inc    = !status.term_even;
                cmd.out_term = status.term_even && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/usg_dp.sv
`timescale 1ns / 1ps

module usg_dp #(
    parameter int HORIZON_MAX = 32767,
    parameter int LIST_CAP    = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [usg_pkg::FIELD_W-1:0]    horizon,
    input  usg_pkg::seed_word_t            seed_data,
    input  usg_pkg::cmd_t                  cmd,
    output usg_pkg::status_t               status,
    output logic                           result_valid,
    input  logic                           result_ready,
    output usg_pkg::result_word_t          result_data
);

    import usg_pkg::*;

    localparam int NMAX = (HORIZON_MAX < FIELD_MAX) ? HORIZON_MAX : FIELD_MAX;
    localparam int VW   = $clog2(NMAX + 1);
    localparam int TAW  = $clog2(NMAX);
    localparam int LW   = (LIST_CAP > 1) ? $clog2(LIST_CAP + 1) : 1;
    localparam int SW   = FIELD_W + 1;

    localparam logic [VW-1:0] NMAX_V = VW'(NMAX);
    localparam logic [LW-1:0] CAP_V  = LW'(LIST_CAP);

    logic [FIELD_W-1:0] a_reg;
    logic [FIELD_W-1:0] b_reg;
    logic [VW-1:0]      x_reg;
    logic [VW-1:0]      s_reg;
    logic [VW-1:0]      clr_reg;
    logic [VW-1:0]      k_reg;
    logic [VW-1:0]      i_reg;
    logic [VW-1:0]      j_reg;
    logic [VW-1:0]      even_cnt_reg;
    logic [FIELD_W-1:0] max_even_reg;
    logic [LW-1:0]      listed_reg;
    logic               out_valid_reg;
    result_word_t       out_word_reg;
    result_word_t       out_word_next;

    logic [VW-1:0]      n_lim;
    logic [SW-1:0]      ab_sum;
    logic               ab_in;
    logic [SW-1:0]      s_sum;
    logic [LW-1:0]      want;
    logic               add_en;
    logic [FIELD_W-1:0] add_val;
    logic               load_out;

    logic               t_we;
    logic [TAW-1:0]     t_waddr;
    logic               t_re;
    logic [TAW-1:0]     t_raddr;
    logic [FIELD_W-1:0] t_rdata;

    logic               r_we;
    logic [VW-1:0]      r_waddr;
    logic [1:0]         r_wdata;
    logic               r_re;
    logic [VW-1:0]      r_raddr;
    logic [1:0]         r_rdata;

    always_comb
    begin
        n_lim = (32'(horizon) > NMAX) ? NMAX_V : VW'(horizon);
    end

    assign ab_sum = SW'(a_reg) + SW'(b_reg);
    assign ab_in  = (ab_sum <= SW'(n_lim));
    assign s_sum  = SW'(t_rdata) + SW'(x_reg);
    assign want   = (32'(even_cnt_reg) < LIST_CAP) ? LW'(even_cnt_reg) : CAP_V;

    // term append
    assign add_en = cmd.seed_a_add || cmd.seed_b_add || cmd.x_add;

    always_comb
    begin
        if (cmd.seed_a_add)
        begin
            add_val = a_reg;
        end
        else if (cmd.seed_b_add)
        begin
            add_val = b_reg;
        end
        else
        begin
            add_val = FIELD_W'(x_reg);
        end
    end

    assign t_we    = add_en;
    assign t_waddr = k_reg[TAW-1:0];
    assign t_re    = cmd.term_rd_i || cmd.term_rd_j;
    assign t_raddr = cmd.term_rd_j ? j_reg[TAW-1:0] : i_reg[TAW-1:0];

    usg_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (NMAX)
    ) u_term_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (add_val),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // representation counts
    always_comb
    begin
        r_we    = 1'b0;
        r_waddr = s_reg;
        r_wdata = REP_ZERO;
        if (cmd.clr_write)
        begin
            r_we    = 1'b1;
            r_waddr = clr_reg;
            r_wdata = REP_ZERO;
        end
        else if (cmd.seed_a_add)
        begin
            r_we    = ab_in;
            r_waddr = ab_sum[VW-1:0];
            r_wdata = REP_ONE;
        end
        else if (cmd.rep_bump)
        begin
            r_we    = (r_rdata != REP_TWO);
            r_waddr = s_reg;
            r_wdata = r_rdata + 2'd1;
        end
    end

    assign r_re    = cmd.rep_rd_x || cmd.rep_rd_s;
    assign r_raddr = cmd.rep_rd_s ? s_sum[VW-1:0] : x_reg;

    usg_ram #(
        .WIDTH (2),
        .DEPTH (NMAX + 1)
    ) u_rep_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign status.bad_seeds  = (seed_data.first_seed == '0)
                               || (seed_data.first_seed >= seed_data.second_seed);
    assign status.clr_done   = (clr_reg == NMAX_V);
    assign status.b_in_range = (SW'(b_reg) < SW'(n_lim));
    assign status.rep_is_one = (r_rdata == REP_ONE);
    assign status.x_at_n     = (x_reg == n_lim);
    assign status.i_at_k     = (i_reg == k_reg);
    assign status.sum_over   = (s_sum > SW'(n_lim));
    assign status.no_even    = (even_cnt_reg == '0);
    assign status.term_even  = !t_rdata[0];
    assign status.last_even  = (LW'(listed_reg + 1'b1) == want);
    assign status.out_free   = !out_valid_reg || result_ready;

    assign load_out = cmd.out_term || cmd.out_none || cmd.out_bad;

    always_comb
    begin
        out_word_next = '0;
        if (cmd.out_bad)
        begin
            out_word_next.bad_pair = 1'b1;
            out_word_next.last     = 1'b1;
        end
        else if (cmd.out_none || status.last_even)
        begin
            out_word_next.term_count = FIELD_W'(k_reg);
            out_word_next.even_count = FIELD_W'(even_cnt_reg);
            out_word_next.max_even   = max_even_reg;
            out_word_next.last       = 1'b1;
        end
        if (cmd.out_term)
        begin
            out_word_next.has_term  = 1'b1;
            out_word_next.even_term = t_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_load)
        begin
            a_reg <= seed_data.first_seed;
            b_reg <= seed_data.second_seed;
        end
        if (cmd.rep_rd_s)
        begin
            s_reg <= s_sum[VW-1:0];
        end
        if (load_out)
        begin
            out_word_reg <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            clr_reg       <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            even_cnt_reg  <= '0;
            max_even_reg  <= '0;
            listed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_init)
            begin
                clr_reg      <= '0;
                k_reg        <= '0;
                even_cnt_reg <= '0;
                max_even_reg <= '0;
            end
            else
            begin
                if (cmd.clr_write)
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                if (add_en)
                begin
                    k_reg <= k_reg + 1'b1;
                    if (!add_val[0])
                    begin
                        even_cnt_reg <= even_cnt_reg + 1'b1;
                        max_even_reg <= add_val;
                    end
                end
            end

            if (cmd.seed_b_add)
            begin
                x_reg <= VW'(SW'(b_reg) + SW'(1));
            end
            else if (cmd.x_inc)
            begin
                x_reg <= x_reg + 1'b1;
            end

            if (cmd.bump_init)
            begin
                i_reg <= '0;
            end
            else if (cmd.rep_bump)
            begin
                i_reg <= i_reg + 1'b1;
            end

            if (cmd.emit_init)
            begin
                j_reg      <= '0;
                listed_reg <= '0;
            end
            else if (cmd.out_term)
            begin
                j_reg      <= j_reg + 1'b1;
                listed_reg <= listed_reg + 1'b1;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_word_reg;

endmodule

FILE: rtl/ulam_sequence_generator.sv
`timescale 1ns / 1ps

// Ulam 1-additive sequence generator.
// seed_ch takes one word per seed pair (first_seed, second_seed); result_ch
// returns the first LIST_CAP even terms of U(a,b) in increasing order, one
// word each, and the word flagged last carries the term count, even count and
// largest even term. A bad pair gives a single word with bad_pair and last set.
// The APB port holds the horizon register at byte address 0 (reset 20000).
// Per good pair the block clears the count memory (min(HORIZON_MAX,32767)+1
// entries), writes both seeds, tests each candidate up to the horizon, sums
// every earlier term with each new term to bump the count memory, and reads
// terms back until the last listed even term goes out. The count and term
// memories, each one read and one write per cycle, set the pace.
// Seeds are taken only between pairs. A result word sits in an output
// register; a stalled receiver holds the emit sequence and nothing is lost.
// Reset returns to idle with the horizon at 20000 and the totals at zero.
module ulam_sequence_generator #(
    parameter int HORIZON_MAX = 32767,
    parameter int LIST_CAP    = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [usg_pkg::PADDR_W-1:0]    paddr,
    input  logic [usg_pkg::PDATA_W-1:0]    pwdata,
    output logic [usg_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    usg_seed_if.sink                       seed_ch,
    usg_result_if.source                   result_ch
);

    import usg_pkg::*;

    logic [FIELD_W-1:0] horizon_reg;
    logic               cfg_hit;
    cmd_t               cmd;
    status_t            status;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1] == REG_HORIZON);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= HORIZON_RESET;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            horizon_reg <= pwdata[FIELD_W-1:0];
        end
    end

    assign prdata = cfg_hit ? PDATA_W'(horizon_reg) : '0;

    usg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_valid (seed_ch.valid),
        .seed_ready (seed_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    usg_dp #(
        .HORIZON_MAX (HORIZON_MAX),
        .LIST_CAP    (LIST_CAP)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .horizon      (horizon_reg),
        .seed_data    (seed_ch.data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.data)
    );

endmodule
